>>> rtl/core/sycc_pkg.sv
// Shared types and constants for the sYCC to RGB converter.
// Used by sycc_matrix and sycc_subsampled_to_rgb_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sycc_pkg;

  // Chroma subsampling modes; the unused code behaves as 4:4:4.
  typedef enum logic [1:0] {
    MODE_444 = 2'd0,
    MODE_422 = 2'd1,
    MODE_420 = 2'd2
  } sub_mode_t;

  // Where the chroma pair of a pixel comes from.
  typedef enum logic [1:0] {
    SRC_FRESH = 2'd0,
    SRC_HELD  = 2'd1,
    SRC_LINE  = 2'd2
  } chroma_src_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_PRECISION  = 2'd0,
    REG_MODE       = 2'd1,
    REG_LINE_WIDTH = 2'd2
  } reg_index_t;

  // Stage load enables handed to the color matrix.
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } matrix_ctl_t;

  // Chroma pair with Cb in the low half and Cr in the high half.
  typedef struct packed {
    logic [15:0] cr;
    logic [15:0] cb;
  } chroma_pair_t;

  // Q16 coefficients, rounded to nearest.
  localparam logic signed [17:0] K_CR_R = 18'sd91881;
  localparam logic signed [17:0] K_CB_G = 18'sd22544;
  localparam logic signed [17:0] K_CR_G = 18'sd46793;
  localparam logic signed [17:0] K_CB_B = 18'sd116130;

endpackage

`default_nettype wire

>>> rtl/core/sycc_matrix.sv
// Two-stage color matrix: constant products, then truncation, luma add and clamp.
// Depends on sycc_pkg for the coefficients and the stage control struct.
`timescale 1ns / 1ps
`default_nettype none

module sycc_matrix
  import sycc_pkg::*;
(
  input  wire logic        clk,
  input  wire matrix_ctl_t ctl,
  input  wire logic [15:0] luma,
  input  wire logic [15:0] cb,
  input  wire logic [15:0] cr,
  input  wire logic [15:0] offset,
  input  wire logic [15:0] upb,
  output logic      [15:0] red,
  output logic      [15:0] green,
  output logic      [15:0] blue
);

  // Truncate a Q16 value toward zero; the integer part fits in 20 bits.
  function automatic logic signed [19:0] trunc_q16(input logic signed [35:0] p);
    logic signed [35:0] biased;
    begin
      biased = p + ((p < 0) ? 36'sd65535 : 36'sd0);
      trunc_q16 = biased[35:16];
    end
  endfunction

  function automatic logic [15:0] clamp_out(input logic signed [20:0] v,
                                            input logic [15:0] hi);
    begin
      if (v < 0) begin
        clamp_out = 16'd0;
      end else if (v > $signed({5'd0, hi})) begin
        clamp_out = hi;
      end else begin
        clamp_out = v[15:0];
      end
    end
  endfunction

  logic signed [16:0] cb_c;
  logic signed [16:0] cr_c;
  logic signed [34:0] prod_r;
  logic signed [34:0] prod_gb;
  logic signed [34:0] prod_gr;
  logic signed [34:0] prod_b;
  logic        [15:0] luma_d;

  logic signed [35:0] g_sum;
  logic signed [19:0] t_r;
  logic signed [19:0] t_g;
  logic signed [19:0] t_b;
  logic signed [20:0] y_ext;
  logic signed [20:0] v_r;
  logic signed [20:0] v_g;
  logic signed [20:0] v_b;

  assign cb_c = $signed({1'b0, cb}) - $signed({1'b0, offset});
  assign cr_c = $signed({1'b0, cr}) - $signed({1'b0, offset});

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r  <= cr_c * K_CR_R;
      prod_gb <= cb_c * K_CB_G;
      prod_gr <= cr_c * K_CR_G;
      prod_b  <= cb_c * K_CB_B;
      luma_d  <= luma;
    end
  end

  always_comb begin
    g_sum = 36'(prod_gb) + 36'(prod_gr);
    t_r   = trunc_q16(36'(prod_r));
    t_g   = trunc_q16(g_sum);
    t_b   = trunc_q16(36'(prod_b));
    y_ext = $signed({5'd0, luma_d});
    v_r   = y_ext + 21'(t_r);
    v_g   = y_ext - 21'(t_g);
    v_b   = y_ext + 21'(t_b);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      red   <= clamp_out(v_r, upb);
      green <= clamp_out(v_g, upb);
      blue  <= clamp_out(v_b, upb);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sycc_subsampled_to_rgb_unit.sv
// sYCC to RGB converter for a raster pixel stream with 4:4:4, 4:2:2 and 4:2:0 chroma.
// Each accepted beat passes the input, product and output registers; throughput is
// one beat per cycle, limited only by output stall. Reset clears the pipeline, the
// counters and the held chroma and loads the register defaults. The chroma line
// buffer is not cleared; an odd 4:2:0 row must follow its even row.
// Depends on sycc_pkg and sycc_matrix.
`timescale 1ns / 1ps
`default_nettype none

module sycc_subsampled_to_rgb_unit
  import sycc_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_PRECISION = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] luma,
  input  wire logic [15:0] chroma_blue,
  input  wire logic [15:0] chroma_red,
  input  wire logic        start_of_frame,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] red,
  output logic      [15:0] green,
  output logic      [15:0] blue
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [4:0]  precision;
  logic [1:0]  subsample_mode;
  logic [12:0] line_width;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision      <= 5'd8;
      subsample_mode <= MODE_444;
      line_width     <= 13'd1920;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[3:2]))
        REG_PRECISION:  precision      <= pwdata[4:0];
        REG_MODE:       subsample_mode <= pwdata[1:0];
        REG_LINE_WIDTH: line_width     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_PRECISION:  prdata = {27'd0, precision};
      REG_MODE:       prdata = {30'd0, subsample_mode};
      REG_LINE_WIDTH: prdata = {19'd0, line_width};
      default:        prdata = 32'd0;
    endcase
  end

  // Effective settings after saturation.
  logic [4:0]       prec_sat;
  logic [CNT_W-1:0] width_sat;
  logic [CNT_W-1:0] width_eff;
  logic [15:0]      offset;
  logic [15:0]      upb;

  always_comb begin
    if (precision == 5'd0) begin
      prec_sat = 5'd1;
    end else if (32'(precision) > MAX_PRECISION) begin
      prec_sat = 5'(MAX_PRECISION);
    end else begin
      prec_sat = precision;
    end
    if (32'(line_width) > MAX_WIDTH) begin
      width_sat = CNT_W'(MAX_WIDTH);
    end else if (line_width < 13'd2) begin
      width_sat = CNT_W'(2);
    end else begin
      width_sat = CNT_W'(line_width);
    end
    width_eff = {width_sat[CNT_W-1:1], 1'b0};
    offset    = 16'(17'd1 << (prec_sat - 5'd1));
    upb       = 16'((17'd1 << prec_sat) - 17'd1);
  end

  // Pipeline flow: input register, product register, output register.
  logic s1_valid;
  logic s2_valid;
  logic s3_free;
  logic s2_free;
  logic s1_free;
  logic s1_move;
  logic s2_move;
  logic accept;

  assign s3_free  = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign s2_move  = s2_valid && s3_free;
  assign accept   = in_valid && s1_free;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Raster position and chroma source selection at accept time.
  logic [CNT_W-1:0]  column_count;
  logic              row_is_odd;
  logic [CNT_W-1:0]  col0;
  logic              row0;
  logic [CNT_W-1:0]  col_inc;
  logic [CNT_W-1:0]  column_count_next;
  logic              row_is_odd_next;
  logic [ADDR_W-1:0] slot;
  chroma_src_t       src;
  logic              held_we;
  logic              line_we;
  logic              line_re;
  chroma_pair_t      fresh;

  assign fresh = '{cr: chroma_red, cb: chroma_blue};

  always_comb begin
    col0 = start_of_frame ? '0 : column_count;
    row0 = start_of_frame ? 1'b0 : row_is_odd;
    if (col0 >= width_eff) begin
      col0 = '0;
    end
    slot    = col0[ADDR_W:1];
    col_inc = col0 + CNT_W'(1);
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_is_odd_next   = !row0;
    end else begin
      column_count_next = col_inc;
      row_is_odd_next   = row0;
    end

    src     = SRC_FRESH;
    held_we = 1'b0;
    line_we = 1'b0;
    line_re = 1'b0;
    if (subsample_mode == MODE_422 || subsample_mode == MODE_420) begin
      if (subsample_mode == MODE_420 && row0) begin
        src     = SRC_LINE;
        held_we = 1'b1;
        line_re = accept;
      end else if (!col0[0]) begin
        held_we = 1'b1;
        line_we = accept && (subsample_mode == MODE_420);
      end else begin
        src = SRC_HELD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_is_odd   <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_is_odd   <= row_is_odd_next;
    end
  end

  // Chroma line buffer: even rows write, odd rows read with a registered port.
  logic [31:0] line_mem [LINE_DEPTH];
  logic [31:0] line_q;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[slot] <= fresh;
    end
    if (line_re) begin
      line_q <= line_mem[slot];
    end
  end

  // Input register
  logic [15:0]  s1_luma;
  chroma_pair_t s1_fresh;
  chroma_src_t  s1_src;
  logic         s1_held_we;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma    <= luma;
      s1_fresh   <= fresh;
      s1_src     <= src;
      s1_held_we <= held_we;
    end
  end

  // The held pair follows the item that leaves the input register, so the
  // next item sees it already updated.
  chroma_pair_t held_chroma;
  chroma_pair_t pair;

  always_comb begin
    case (s1_src)
      SRC_FRESH: pair = s1_fresh;
      SRC_HELD:  pair = held_chroma;
      SRC_LINE:  pair = line_q;
      default:   pair = s1_fresh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_chroma <= '0;
    end else if (s1_move && s1_held_we) begin
      held_chroma <= pair;
    end
  end

  matrix_ctl_t mctl;

  assign mctl = '{load_prod: s1_move, load_out: s2_move};

  sycc_matrix u_matrix (
    .clk    (clk),
    .ctl    (mctl),
    .luma   (s1_luma),
    .cb     (pair.cb),
    .cr     (pair.cr),
    .offset (offset),
    .upb    (upb),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for sycc_subsampled_to_rgb_unit: random and directed pixel beats
// with a bit-exact color predictor, APB register writes and randomized idle and stall.
// Depends on sycc_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module tb;
  import sycc_pkg::*;

  localparam int LINE_MAX = 4096;
  localparam int PREC_MAX = 16;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Q16 color coefficients, rounded to nearest.
  localparam longint Q16_CR_R = 91881;
  localparam longint Q16_CB_G = 22544;
  localparam longint Q16_CR_G = 46793;
  localparam longint Q16_CB_B = 116130;

  typedef struct packed {
    logic        sof;
    logic [15:0] luma;
    logic [15:0] cb;
    logic [15:0] cr;
  } pixel_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] luma = '0;
  logic [15:0] chroma_blue = '0;
  logic [15:0] chroma_red = '0;
  logic        start_of_frame = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  sycc_subsampled_to_rgb_unit #(
    .MAX_WIDTH(LINE_MAX),
    .MAX_PRECISION(PREC_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .luma(luma),
    .chroma_blue(chroma_blue),
    .chroma_red(chroma_red),
    .start_of_frame(start_of_frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies and converter state as the predictor sees them.
  logic [4:0]   cfg_prec = 5'd8;
  logic [1:0]   cfg_mode = MODE_444;
  logic [12:0]  cfg_width = 13'd1920;
  int           column = 0;
  logic         odd_row = 1'b0;
  chroma_pair_t held_pair = '0;
  chroma_pair_t chroma_row [0:LINE_MAX/2-1];

  pixel_t pending_pixels [$];
  rgb_t   expected_rgb [$];
  pixel_t next_px;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     error_count = 0;
  int     phase_idx = 0;

  function automatic longint q16_to_int(input longint p);
    if (p < 0) return -((-p) >>> 16);
    return p >>> 16;
  endfunction

  function automatic logic [15:0] clamp_sample(input longint v, input longint top);
    if (v < 0) return 16'd0;
    if (v > top) return top[15:0];
    return v[15:0];
  endfunction

  // Advances the stream position by one pixel and returns its RGB value.
  function automatic rgb_t convert_pixel(input pixel_t px);
    int prec;
    int width;
    int slot;
    chroma_pair_t fresh;
    chroma_pair_t pair;
    longint offset;
    longint top;
    longint y;
    longint cb;
    longint cr;
    rgb_t res;
    prec = cfg_prec;
    if (prec < 1) prec = 1;
    if (prec > PREC_MAX) prec = PREC_MAX;
    width = cfg_width;
    if (width < 2) width = 2;
    if (width > LINE_MAX) width = LINE_MAX;
    width = width - (width % 2);
    if (px.sof) begin
      column = 0;
      odd_row = 1'b0;
    end
    if (column >= width) column = 0;
    fresh.cb = px.cb;
    fresh.cr = px.cr;
    slot = column / 2;
    if (cfg_mode == MODE_422 || cfg_mode == MODE_420) begin
      if (cfg_mode == MODE_420 && odd_row) begin
        pair = chroma_row[slot];
        held_pair = pair;
      end else if (column % 2 == 0) begin
        pair = fresh;
        held_pair = fresh;
        if (cfg_mode == MODE_420) chroma_row[slot] = fresh;
      end else begin
        pair = held_pair;
      end
    end else begin
      pair = fresh;
    end
    offset = longint'(1) << (prec - 1);
    top = (longint'(1) << prec) - 1;
    y = px.luma;
    cb = pair.cb;
    cb = cb - offset;
    cr = pair.cr;
    cr = cr - offset;
    res.red = clamp_sample(y + q16_to_int(cr * Q16_CR_R), top);
    res.green = clamp_sample(y - q16_to_int(cb * Q16_CB_G + cr * Q16_CR_G), top);
    res.blue = clamp_sample(y + q16_to_int(cb * Q16_CB_B), top);
    column = column + 1;
    if (column >= width) begin
      column = 0;
      odd_row = ~odd_row;
    end
    return res;
  endfunction

  // Input driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_rgb.push_back(convert_pixel({start_of_frame, luma, chroma_blue, chroma_red}));
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_px = pending_pixels.pop_front();
          luma <= next_px.luma;
          chroma_blue <= next_px.cb;
          chroma_red <= next_px.cr;
          start_of_frame <= next_px.sof;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Output monitor: compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rgb.size() == 0) begin
          error_count++;
          $display("%0t ns: result beat with none expected, got %0d %0d %0d",
                   $time, red, green, blue);
        end else begin
          rgb_t want;
          want = expected_rgb.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PRECISION:  cfg_prec = value[4:0];
      REG_MODE:       cfg_mode = value[1:0];
      REG_LINE_WIDTH: cfg_width = value[12:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_rgb.size() != 0);
  endtask

  task automatic run_phase(input logic [4:0] prec, input logic [1:0] mode,
                           input logic [12:0] width, input int count);
    int eff_prec;
    int mask;
    int split;
    pixel_t px;
    eff_prec = prec;
    if (eff_prec < 1) eff_prec = 1;
    if (eff_prec > PREC_MAX) eff_prec = PREC_MAX;
    mask = (1 << eff_prec) - 1;
    case (phase_idx % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 83; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 83; end
      default: begin send_idle_pct = 27; stall_pct = 27; end
    endcase
    phase_idx++;
    write_reg(REG_PRECISION, {27'd0, prec});
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_LINE_WIDTH, {19'd0, width});
    split = $urandom_range(count - 2, 1);
    for (int i = 0; i < count; i++) begin
      // Each phase opens a new frame, so an odd 4:2:0 row always follows its even row.
      px.sof = (i == 0) || ($urandom_range(24) == 0);
      for (int f = 0; f < 3; f++) begin
        int v;
        case ($urandom_range(3))
          0: v = $urandom_range(65535);
          1, 2: v = $urandom & mask;
          default: v = $urandom_range(1) ? mask : 0;
        endcase
        case (f)
          0: px.luma = v[15:0];
          1: px.cb = v[15:0];
          default: px.cr = v[15:0];
        endcase
      end
      pending_pixels.push_back(px);
      // Hold the sender once until the pipeline has emptied.
      if (i == split) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, 4:4:4 at 8 bits: sample extremes and neutral chroma.
    pending_pixels.push_back({1'b1, 16'd0, 16'd0, 16'd0});
    pending_pixels.push_back({1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_pixels.push_back({1'b0, 16'd255, 16'd128, 16'd128});
    pending_pixels.push_back({1'b0, 16'd0, 16'd255, 16'd255});
    pending_pixels.push_back({1'b0, 16'd255, 16'd0, 16'd0});
    pending_pixels.push_back({1'b0, 16'd0, 16'd0, 16'd255});
    pending_pixels.push_back({1'b0, 16'd255, 16'd255, 16'd0});
    pending_pixels.push_back({1'b0, 16'd128, 16'hFFFF, 16'd0});
    wait_drained();

    // 4:2:0 at 16 bits on a four pixel line: two full rows, then a frame restart mid-row.
    write_reg(REG_PRECISION, 32'd16);
    write_reg(REG_MODE, {30'd0, MODE_420});
    write_reg(REG_LINE_WIDTH, 32'd4);
    pending_pixels.push_back({1'b1, 16'd100, 16'h1000, 16'hF000});
    pending_pixels.push_back({1'b0, 16'd200, 16'hAAAA, 16'h5555});
    pending_pixels.push_back({1'b0, 16'hFFFF, 16'hFFFF, 16'h0000});
    pending_pixels.push_back({1'b0, 16'd0, 16'd1, 16'd2});
    pending_pixels.push_back({1'b0, 16'h8000, 16'h0000, 16'hFFFF});
    pending_pixels.push_back({1'b0, 16'h8000, 16'h1234, 16'h4321});
    pending_pixels.push_back({1'b0, 16'h0000, 16'h8000, 16'h8000});
    pending_pixels.push_back({1'b0, 16'hFFFF, 16'h7FFF, 16'h8001});
    pending_pixels.push_back({1'b0, 16'h4000, 16'h2222, 16'hDDDD});
    pending_pixels.push_back({1'b0, 16'h4000, 16'h9999, 16'h6666});
    pending_pixels.push_back({1'b1, 16'h1234, 16'h8000, 16'h8000});
    wait_drained();

    run_phase(5'd8,  MODE_422,      13'd6,    40);
    run_phase(5'd10, MODE_420,      13'd4,    40);
    run_phase(5'd16, MODE_420,      13'd8,    40);
    run_phase(5'd1,  MODE_420,      13'd2,    30);
    run_phase(5'd0,  MODE_422,      13'd0,    20);
    run_phase(5'd31, MODE_420,      13'd7,    40);
    run_phase(5'd12, MODE_RESERVED, 13'd13,   30);
    run_phase(5'd16, MODE_422,      13'd8191, 30);
    run_phase(5'd20, MODE_420,      13'd4096, 30);
    run_phase(5'd5,  MODE_444,      13'd2,    30);
    run_phase(5'd9,  MODE_420,      13'd10,   40);
    run_phase(5'd8,  MODE_420,      13'd1,    40);
    run_phase(5'd16, MODE_444,      13'd4096, 20);

    // Give a stray late beat the chance to show up before the verdict.
    repeat (10) @(posedge clk);
    if (expected_rgb.size() != 0) error_count++;
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sycc_pkg.sv
rtl/core/sycc_matrix.sv
rtl/core/sycc_subsampled_to_rgb_unit.sv
sim/tb.sv
